@@ hdl/pscb_pkg.sv @@
// shared types, constants and helpers of the pendulum swing-up and balance controller
package pscb_pkg;

  localparam int FRAC_BITS = 16;

  // operand width of the shared multiplier and width of its kept product
  localparam int MUL_W  = 34;
  localparam int PROD_W = 64;

  // shared divider: dividend magnitude bits, divisor bits, quotient bits per cycle
  localparam int DIV_W     = 56;
  localparam int DVS_W     = 16;
  localparam int DIV_STEP  = 4;
  localparam int DIV_ITERS = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  localparam int COS_TERMS = 6;
  localparam int ITER_W    = $clog2(COS_TERMS);
  localparam logic [ITER_W-1:0] COS_LAST = ITER_W'(COS_TERMS - 1);

  localparam longint PI48      = 64'sh3243F6A8885A3;
  localparam longint PI_Q      = (PI48 + (64'sd1 <<< (47 - FRAC_BITS))) >>> (48 - FRAC_BITS);
  localparam longint TWO_PI_Q  = (2 * PI48 + (64'sd1 <<< (47 - FRAC_BITS))) >>> (48 - FRAC_BITS);
  localparam longint PI30      = (PI48 + (64'sd1 <<< 17)) >>> 18;
  localparam longint HALF_PI30 = (PI48 + (64'sd1 <<< 18)) >>> 19;
  localparam longint ONE30     = 64'sd1 <<< 30;
  localparam longint ONE_Q     = 64'sd1 <<< FRAC_BITS;
  localparam longint COS_RND   = 64'sd1 <<< (29 - FRAC_BITS);
  localparam longint BAND_LO   = ((64'sd312 <<< FRAC_BITS) + 50) / 100;
  localparam longint BAND_HI   = ((64'sd316 <<< FRAC_BITS) + 50) / 100;

  localparam longint PCNT_REV  = 8200;
  localparam longint WCNT_REV  = 800;
  localparam longint PCNT_HALF = PCNT_REV / 2;
  localparam longint WCNT_HALF = WCNT_REV / 2;
  localparam longint US_PER_S  = 1000000;

  typedef enum logic [2:0] {
    REG_GAIN_PA   = 3'd0,
    REG_GAIN_PR   = 3'd1,
    REG_GAIN_WA   = 3'd2,
    REG_GAIN_WR   = 3'd3,
    REG_INERTIA   = 3'd4,
    REG_MGL       = 3'd5,
    REG_EREF      = 3'd6,
    REG_SWING     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] gain_pa;
    logic signed [31:0] gain_pr;
    logic signed [31:0] gain_wa;
    logic signed [31:0] gain_wr;
    logic [30:0]        inertia;
    logic [30:0]        mgl;
    logic signed [31:0] eref;
    logic signed [31:0] swing_gain;
  } cfg_t;

  typedef enum logic [2:0] {CS_IDLE, CS_EXEC, CS_WAIT, CS_WB, CS_HOLD} ctrl_state_t;

  typedef enum logic [4:0] {
    ST_BAL0, ST_BAL1, ST_BAL2, ST_BAL3,
    ST_SW_R2, ST_SW_KIN,
    ST_COS_FOLD, ST_COS_SQ, ST_COS_MUL, ST_COS_DIV, ST_COS_ROUND,
    ST_SW_POT, ST_SW_GAIN, ST_SW_DRIVE,
    ST_CV_MOD, ST_CV_PMUL, ST_CV_PDIV, ST_CV_WMUL, ST_CV_WDIV,
    ST_RT_PMUL, ST_RT_PDIV, ST_RT_WMUL, ST_RT_WDIV
  } step_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic              div_start;
    logic              wb;
    logic              publish;
    step_t             step;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic in_band;
    logic div_done;
    logic out_busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

@@ hdl/pscb_if.sv @@
// request channels of the controller: encoder samples in, drive commands out
interface pscb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pendulum_count;
  logic signed [31:0] wheel_count;
  logic [15:0]        elapsed_us;

  modport source (output valid, pendulum_count, wheel_count, elapsed_us, input ready);
  modport sink (input valid, pendulum_count, wheel_count, elapsed_us, output ready);
endinterface

interface pscb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               balancing;

  modport source (output valid, drive, balancing, input ready);
  modport sink (input valid, drive, balancing, output ready);
endinterface

@@ hdl/pendulum_swingup_balance_control.sv @@
// top level of the pendulum swing-up and balance controller
//
// in_ch carries one encoder sample per request (pendulum count, wheel count,
// microseconds since the previous sample); out_ch returns one drive command per
// sample together with a flag that tells whether the balance law was used.
// Gains and plant constants sit in eight 32-bit registers at byte addresses
// 0x00 to 0x1c on the psel/penable register port; write them only while idle.
// One sample is worked at a time by a sequencer over a shared 34x34 multiplier
// and a divider that retires four quotient bits per cycle. A swing-up sample
// adds a six-term cosine series to the path of a sample near upright. The
// divisions dominate the time of a sample: five per sample near upright,
// eleven in swing-up. A new sample is taken only once the last one is
// through the sequencer and its command is in the output register.
// The finished command waits in an output register, so the next sample is
// accepted while it is still waiting; a stalled receiver holds the sequencer
// only when a second command is ready to be written.
// Reset (rst_n low, synchronous) clears the angles, rates and error vector and
// reloads the default gains; no request is in flight afterwards.
module pendulum_swingup_balance_control (
  input  logic         clk,
  input  logic         rst_n,
  pscb_in_if.sink      in_ch,
  pscb_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  pscb_pkg::cfg_t    cfg;
  pscb_pkg::cmd_t    cmd;
  pscb_pkg::status_t status;
  logic              in_ready;

  pscb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pscb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pscb_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .status            (status),
    .in_pendulum_count (in_ch.pendulum_count),
    .in_wheel_count    (in_ch.wheel_count),
    .in_elapsed_us     (in_ch.elapsed_us),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_drive         (out_ch.drive),
    .out_balancing     (out_ch.balancing)
  );

  assign in_ch.ready = in_ready;

endmodule

@@ hdl/pscb_div.sv @@
// iterative signed divider, several quotient bits per cycle, truncating or floor quotient
module pscb_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          floor_mode,
  input  logic signed [63:0]            dividend,
  input  logic [pscb_pkg::DVS_W-1:0]    divisor,
  output logic                          done,
  output logic signed [63:0]            quot,
  output logic signed [pscb_pkg::DVS_W:0] rem
);

  logic                           busy_r;
  logic                           done_r;
  logic [pscb_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [pscb_pkg::DIV_W-1:0]     num_r;
  logic [pscb_pkg::DVS_W-1:0]     rem_r;
  logic [pscb_pkg::DVS_W-1:0]     dvs_r;
  logic                           neg_r;
  logic                           flr_r;

  logic [pscb_pkg::DIV_W-1:0]     num_nxt;
  logic [pscb_pkg::DVS_W-1:0]     rem_nxt;
  logic [pscb_pkg::DVS_W:0]       trial;
  logic signed [63:0]             mag;
  logic signed [63:0]             qs;

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < pscb_pkg::DIV_STEP; i++) begin
      trial   = {rem_nxt, num_nxt[pscb_pkg::DIV_W-1]};
      num_nxt = {num_nxt[pscb_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = trial[pscb_pkg::DVS_W-1:0];
    end
  end

  assign mag  = dividend[63] ? -dividend : dividend;
  assign qs   = neg_r ? -$signed(64'(num_r)) : $signed(64'(num_r));
  // floor quotient steps one further down when a negative dividend leaves a remainder
  assign quot = (flr_r && neg_r && (rem_r != '0)) ? qs - 64'sd1 : qs;
  assign rem  = neg_r ? -$signed({1'b0, rem_r}) : $signed({1'b0, rem_r});
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= mag[pscb_pkg::DIV_W-1:0];
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[63];
      flr_r <= floor_mode;
      cnt_r <= pscb_pkg::DIV_CNT_W'(pscb_pkg::DIV_ITERS - 1);
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ hdl/pscb_regs.sv @@
// configuration register file behind the write/read register port
module pscb_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pscb_pkg::cfg_t     cfg
);

  pscb_pkg::cfg_t   cfg_r;
  pscb_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = pscb_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_pa    <= -32'sd1190861;
      cfg_r.gain_pr    <= -32'sd113141;
      cfg_r.gain_wa    <= 32'sd203;
      cfg_r.gain_wr    <= 32'sd98;
      cfg_r.inertia    <= '0;
      cfg_r.mgl        <= '0;
      cfg_r.eref       <= '0;
      cfg_r.swing_gain <= 32'sd524288;
    end else if (wr_en) begin
      case (idx)
        pscb_pkg::REG_GAIN_PA: cfg_r.gain_pa    <= pwdata;
        pscb_pkg::REG_GAIN_PR: cfg_r.gain_pr    <= pwdata;
        pscb_pkg::REG_GAIN_WA: cfg_r.gain_wa    <= pwdata;
        pscb_pkg::REG_GAIN_WR: cfg_r.gain_wr    <= pwdata;
        pscb_pkg::REG_INERTIA: cfg_r.inertia    <= pwdata[30:0];
        pscb_pkg::REG_MGL:     cfg_r.mgl        <= pwdata[30:0];
        pscb_pkg::REG_EREF:    cfg_r.eref       <= pwdata;
        pscb_pkg::REG_SWING:   cfg_r.swing_gain <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pscb_pkg::REG_GAIN_PA: prdata = cfg_r.gain_pa;
      pscb_pkg::REG_GAIN_PR: prdata = cfg_r.gain_pr;
      pscb_pkg::REG_GAIN_WA: prdata = cfg_r.gain_wa;
      pscb_pkg::REG_GAIN_WR: prdata = cfg_r.gain_wr;
      pscb_pkg::REG_INERTIA: prdata = 32'(cfg_r.inertia);
      pscb_pkg::REG_MGL:     prdata = 32'(cfg_r.mgl);
      pscb_pkg::REG_EREF:    prdata = cfg_r.eref;
      pscb_pkg::REG_SWING:   prdata = cfg_r.swing_gain;
      default:               prdata = '0;
    endcase
  end

endmodule

@@ hdl/pscb_ctrl.sv @@
// sequencer that walks one sample through the shared multiplier and divider
module pscb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pscb_pkg::status_t  status,
  output pscb_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {KIND_NONE, KIND_MUL, KIND_DIV} kind_t;

  pscb_pkg::ctrl_state_t       state_r, state_nxt;
  pscb_pkg::step_t             step_r, step_nxt;
  logic [pscb_pkg::ITER_W-1:0] iter_r, iter_nxt;
  kind_t                       kind;

  function automatic kind_t step_kind(input pscb_pkg::step_t s);
    case (s)
      pscb_pkg::ST_COS_FOLD, pscb_pkg::ST_COS_ROUND: return KIND_NONE;
      pscb_pkg::ST_COS_DIV, pscb_pkg::ST_CV_MOD, pscb_pkg::ST_CV_PDIV,
      pscb_pkg::ST_CV_WDIV, pscb_pkg::ST_RT_PDIV, pscb_pkg::ST_RT_WDIV: return KIND_DIV;
      default: return KIND_MUL;
    endcase
  endfunction

  function automatic pscb_pkg::step_t next_step(input pscb_pkg::step_t s,
                                                input logic [pscb_pkg::ITER_W-1:0] it);
    case (s)
      pscb_pkg::ST_BAL0:      return pscb_pkg::ST_BAL1;
      pscb_pkg::ST_BAL1:      return pscb_pkg::ST_BAL2;
      pscb_pkg::ST_BAL2:      return pscb_pkg::ST_BAL3;
      pscb_pkg::ST_BAL3:      return pscb_pkg::ST_CV_MOD;
      pscb_pkg::ST_SW_R2:     return pscb_pkg::ST_SW_KIN;
      pscb_pkg::ST_SW_KIN:    return pscb_pkg::ST_COS_FOLD;
      pscb_pkg::ST_COS_FOLD:  return pscb_pkg::ST_COS_SQ;
      pscb_pkg::ST_COS_SQ:    return pscb_pkg::ST_COS_MUL;
      pscb_pkg::ST_COS_MUL:   return pscb_pkg::ST_COS_DIV;
      pscb_pkg::ST_COS_DIV:
        return (it == pscb_pkg::COS_LAST) ? pscb_pkg::ST_COS_ROUND : pscb_pkg::ST_COS_MUL;
      pscb_pkg::ST_COS_ROUND: return pscb_pkg::ST_SW_POT;
      pscb_pkg::ST_SW_POT:    return pscb_pkg::ST_SW_GAIN;
      pscb_pkg::ST_SW_GAIN:   return pscb_pkg::ST_SW_DRIVE;
      pscb_pkg::ST_SW_DRIVE:  return pscb_pkg::ST_CV_MOD;
      pscb_pkg::ST_CV_MOD:    return pscb_pkg::ST_CV_PMUL;
      pscb_pkg::ST_CV_PMUL:   return pscb_pkg::ST_CV_PDIV;
      pscb_pkg::ST_CV_PDIV:   return pscb_pkg::ST_CV_WMUL;
      pscb_pkg::ST_CV_WMUL:   return pscb_pkg::ST_CV_WDIV;
      pscb_pkg::ST_CV_WDIV:   return pscb_pkg::ST_RT_PMUL;
      pscb_pkg::ST_RT_PMUL:   return pscb_pkg::ST_RT_PDIV;
      pscb_pkg::ST_RT_PDIV:   return pscb_pkg::ST_RT_WMUL;
      pscb_pkg::ST_RT_WMUL:   return pscb_pkg::ST_RT_WDIV;
      default:                return pscb_pkg::ST_RT_WDIV;
    endcase
  endfunction

  assign kind = step_kind(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pscb_pkg::CS_IDLE;
      step_r  <= pscb_pkg::ST_BAL0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    iter_nxt      = iter_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = step_r;
    cmd.iter      = iter_r;
    case (state_r)
      pscb_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          // law is picked from the angle stored by the previous sample
          step_nxt  = status.in_band ? pscb_pkg::ST_BAL0 : pscb_pkg::ST_SW_R2;
          iter_nxt  = '0;
          state_nxt = pscb_pkg::CS_EXEC;
        end
      end
      pscb_pkg::CS_EXEC: begin
        case (kind)
          KIND_MUL: begin
            cmd.mul_en = 1'b1;
            state_nxt  = pscb_pkg::CS_WB;
          end
          KIND_DIV: begin
            cmd.div_start = 1'b1;
            state_nxt     = pscb_pkg::CS_WAIT;
          end
          default: state_nxt = pscb_pkg::CS_WB;
        endcase
      end
      pscb_pkg::CS_WAIT: begin
        if (status.div_done) state_nxt = pscb_pkg::CS_WB;
      end
      pscb_pkg::CS_WB: begin
        cmd.wb = 1'b1;
        if (step_r == pscb_pkg::ST_RT_WDIV) begin
          state_nxt = pscb_pkg::CS_HOLD;
        end else begin
          step_nxt  = next_step(step_r, iter_r);
          if (step_r == pscb_pkg::ST_COS_DIV) iter_nxt = iter_r + 1'b1;
          state_nxt = pscb_pkg::CS_EXEC;
        end
      end
      pscb_pkg::CS_HOLD: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = pscb_pkg::CS_IDLE;
        end
      end
      default: state_nxt = pscb_pkg::CS_IDLE;
    endcase
  end

endmodule

@@ hdl/pscb_dpath.sv @@
// datapath: state registers, shared multiplier, divider and result register
module pscb_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  pscb_pkg::cfg_t     cfg,
  input  pscb_pkg::cmd_t     cmd,
  output pscb_pkg::status_t  status,
  input  logic signed [31:0] in_pendulum_count,
  input  logic signed [31:0] in_wheel_count,
  input  logic [15:0]        in_elapsed_us,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_drive,
  output logic               out_balancing
);

  localparam int SH30 = 30;
  localparam int CSH  = 30 - pscb_pkg::FRAC_BITS;

  // latched sample
  logic signed [31:0] pc_r, wc_r;
  logic [15:0]        dt_r;
  // controller state
  logic signed [31:0] p_ang_r, p_rate_r, w_ang_r, w_rate_r;
  logic signed [31:0] ev_r [4];
  // scratch
  logic signed [63:0] acc_r;
  logic signed [63:0] prod_r;
  logic signed [pscb_pkg::MUL_W-1:0] va_r, vb_r, x_r, y2_r, t_r;
  logic               neg_r;
  logic signed [31:0] np_r, nw_r;
  logic signed [31:0] drive_r;
  logic               bal_r;
  // result register
  logic               out_valid_r;
  logic signed [31:0] out_drive_r;
  logic               out_bal_r;

  logic signed [pscb_pkg::MUL_W-1:0]   ma, mb;
  logic signed [2*pscb_pkg::MUL_W-1:0] pfull;
  logic signed [63:0] p16, p30, p16a;
  logic signed [31:0] p16s, qsat, es, de, nw_new;
  logic signed [35:0] x0, x1, x2, tt, cosv;
  logic signed [35:0] pdiff;
  logic               fold_neg;
  logic signed [63:0] div_dvd;
  logic [pscb_pkg::DVS_W-1:0] div_dvs;
  logic               div_floor;
  logic               div_done;
  logic signed [63:0] div_quot;
  logic signed [pscb_pkg::DVS_W:0] div_rem;
  logic signed [pscb_pkg::MUL_W-1:0] cv_rem;
  logic signed [63:0] np_q;

  function automatic logic [pscb_pkg::DVS_W-1:0] cos_div(input logic [pscb_pkg::ITER_W-1:0] i);
    case (i)
      3'd0:    return 16'd132;
      3'd1:    return 16'd90;
      3'd2:    return 16'd56;
      3'd3:    return 16'd30;
      3'd4:    return 16'd12;
      default: return 16'd2;
    endcase
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.step)
      pscb_pkg::ST_BAL0:     begin ma = 34'(cfg.gain_pa); mb = 34'(ev_r[0]); end
      pscb_pkg::ST_BAL1:     begin ma = 34'(cfg.gain_pr); mb = 34'(ev_r[1]); end
      pscb_pkg::ST_BAL2:     begin ma = 34'(cfg.gain_wa); mb = 34'(ev_r[2]); end
      pscb_pkg::ST_BAL3:     begin ma = 34'(cfg.gain_wr); mb = 34'(ev_r[3]); end
      pscb_pkg::ST_SW_R2:    begin ma = 34'(p_rate_r); mb = 34'(p_rate_r); end
      pscb_pkg::ST_SW_KIN:   begin ma = $signed(34'(cfg.inertia)); mb = va_r; end
      pscb_pkg::ST_COS_SQ:   begin ma = x_r; mb = x_r; end
      pscb_pkg::ST_COS_MUL:  begin ma = y2_r; mb = t_r; end
      pscb_pkg::ST_SW_POT:   begin ma = $signed(34'(cfg.mgl)); mb = vb_r; end
      pscb_pkg::ST_SW_GAIN:  begin ma = 34'(cfg.swing_gain); mb = vb_r; end
      pscb_pkg::ST_SW_DRIVE: begin ma = vb_r; mb = 34'(p_rate_r); end
      pscb_pkg::ST_CV_PMUL:  begin ma = va_r; mb = 34'(pscb_pkg::TWO_PI_Q); end
      pscb_pkg::ST_CV_WMUL:  begin ma = 34'(wc_r); mb = 34'(pscb_pkg::TWO_PI_Q); end
      pscb_pkg::ST_RT_PMUL:  begin ma = va_r; mb = 34'(pscb_pkg::US_PER_S); end
      pscb_pkg::ST_RT_WMUL:  begin
        ma = 34'(nw_r) - 34'(w_ang_r);
        mb = 34'(pscb_pkg::US_PER_S);
      end
      default:               begin ma = '0; mb = '0; end
    endcase
  end

  assign pfull = ma * mb;

  // divider operand select
  always_comb begin
    div_dvd   = acc_r;
    div_floor = 1'b0;
    case (cmd.step)
      pscb_pkg::ST_CV_MOD: begin
        div_dvd = 64'(pc_r);
        div_dvs = 16'(pscb_pkg::PCNT_REV);
      end
      pscb_pkg::ST_CV_PDIV: begin
        div_dvs   = 16'(pscb_pkg::PCNT_REV);
        div_floor = 1'b1;
      end
      pscb_pkg::ST_CV_WDIV: begin
        div_dvs   = 16'(pscb_pkg::WCNT_REV);
        div_floor = 1'b1;
      end
      pscb_pkg::ST_COS_DIV: div_dvs = cos_div(cmd.iter);
      default: div_dvs = (dt_r == '0) ? 16'd1 : dt_r;
    endcase
  end

  pscb_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.div_start),
    .floor_mode (div_floor),
    .dividend   (div_dvd),
    .divisor    (div_dvs),
    .done       (div_done),
    .quot       (div_quot),
    .rem        (div_rem)
  );

  // write-back arithmetic
  always_comb begin
    p16    = prod_r >>> pscb_pkg::FRAC_BITS;
    p30    = prod_r >>> SH30;
    p16s   = pscb_pkg::sat32(p16);
    p16a   = acc_r + p16;
    qsat   = pscb_pkg::sat32(div_quot);
    es     = pscb_pkg::sat32(64'(va_r) + 64'(p16s));
    de     = pscb_pkg::sat32(64'(es) - 64'(cfg.eref));
    nw_new = qsat;
    cv_rem = (div_rem < 0) ? 34'(div_rem) + 34'(pscb_pkg::PCNT_REV) : 34'(div_rem);
    np_q   = (div_quot >= pscb_pkg::TWO_PI_Q) ? div_quot - pscb_pkg::TWO_PI_Q : div_quot;

    // fold the angle into the first quadrant, remembering the sign flip
    x0 = 36'(p_ang_r) <<< CSH;
    x1 = (x0 > 36'(pscb_pkg::PI30)) ? 36'(2 * pscb_pkg::PI30) - x0 : x0;
    if (x1 < 0) x1 = '0;
    fold_neg = x1 > 36'(pscb_pkg::HALF_PI30);
    x2 = fold_neg ? 36'(pscb_pkg::PI30) - x1 : x1;
    if (x2 < 0) x2 = '0;

    tt   = neg_r ? -36'(t_r) : 36'(t_r);
    cosv = (tt + 36'(pscb_pkg::COS_RND)) >>> CSH;

    // pendulum step wrapped to [-pi, pi)
    pdiff = 36'(np_r) - 36'(p_ang_r);
    if (pdiff >= 36'(pscb_pkg::PI_Q)) pdiff = pdiff - 36'(pscb_pkg::TWO_PI_Q);
    if (pdiff < -36'(pscb_pkg::PI_Q)) pdiff = pdiff + 36'(pscb_pkg::TWO_PI_Q);
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ang_r     <= '0;
      p_rate_r    <= '0;
      w_ang_r     <= '0;
      w_rate_r    <= '0;
      ev_r[0]     <= '0;
      ev_r[1]     <= '0;
      ev_r[2]     <= '0;
      ev_r[3]     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.publish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.wb) begin
        case (cmd.step)
          pscb_pkg::ST_CV_WDIV: begin
            ev_r[0] <= 32'(64'(np_r) - pscb_pkg::PI_Q);
            ev_r[1] <= p_rate_r;
            ev_r[2] <= nw_new;
            ev_r[3] <= w_rate_r;
          end
          pscb_pkg::ST_RT_PDIV: p_rate_r <= qsat;
          pscb_pkg::ST_RT_WDIV: begin
            w_rate_r <= qsat;
            p_ang_r  <= np_r;
            w_ang_r  <= nw_r;
          end
          default: ;
        endcase
      end
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pc_r <= in_pendulum_count;
      wc_r <= in_wheel_count;
      dt_r <= in_elapsed_us;
    end
    if (cmd.mul_en) prod_r <= pfull[63:0];
    if (cmd.publish) begin
      out_drive_r <= drive_r;
      out_bal_r   <= bal_r;
    end
    if (cmd.wb) begin
      case (cmd.step)
        pscb_pkg::ST_BAL0:      acc_r <= p16;
        pscb_pkg::ST_BAL1,
        pscb_pkg::ST_BAL2:      acc_r <= p16a;
        pscb_pkg::ST_BAL3: begin
          drive_r <= pscb_pkg::sat32(p16a);
          bal_r   <= 1'b1;
        end
        pscb_pkg::ST_SW_R2:     va_r <= 34'(p16s);
        pscb_pkg::ST_SW_KIN:    va_r <= 34'(p16s) >>> 1;
        pscb_pkg::ST_COS_FOLD: begin
          x_r   <= x2[pscb_pkg::MUL_W-1:0];
          neg_r <= fold_neg;
          t_r   <= 34'(pscb_pkg::ONE30);
        end
        pscb_pkg::ST_COS_SQ:    y2_r <= p30[pscb_pkg::MUL_W-1:0];
        pscb_pkg::ST_COS_MUL:   acc_r <= p30;
        pscb_pkg::ST_COS_DIV:   t_r <= 34'(pscb_pkg::ONE30 - div_quot);
        pscb_pkg::ST_COS_ROUND: vb_r <= 34'(pscb_pkg::ONE_Q) - cosv[pscb_pkg::MUL_W-1:0];
        pscb_pkg::ST_SW_POT:    vb_r <= 34'(de);
        pscb_pkg::ST_SW_GAIN:   vb_r <= 34'(p16s);
        pscb_pkg::ST_SW_DRIVE: begin
          drive_r <= p16s;
          bal_r   <= 1'b0;
        end
        pscb_pkg::ST_CV_MOD:    va_r <= cv_rem;
        pscb_pkg::ST_CV_PMUL:   acc_r <= prod_r + pscb_pkg::PCNT_HALF;
        pscb_pkg::ST_CV_PDIV:   np_r <= np_q[31:0];
        pscb_pkg::ST_CV_WMUL:   acc_r <= prod_r + pscb_pkg::WCNT_HALF;
        pscb_pkg::ST_CV_WDIV: begin
          nw_r <= nw_new;
          va_r <= pdiff[pscb_pkg::MUL_W-1:0];
        end
        pscb_pkg::ST_RT_PMUL,
        pscb_pkg::ST_RT_WMUL:   acc_r <= prod_r;
        default: ;
      endcase
    end
  end

  assign status.in_band  = (p_ang_r > 32'(pscb_pkg::BAND_LO)) &&
                           (p_ang_r < 32'(pscb_pkg::BAND_HI));
  assign status.div_done = div_done;
  assign status.out_busy = out_valid_r & ~out_ready;

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_balancing = out_bal_r;

endmodule

@@ dv/tb_top.sv @@
// testbench for the pendulum swing-up and balance controller: directed table plus random samples
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint gpa, gpr, gwa, gwr, inertia, mgl, eref, swing;
  } ctl_regs_t;

  typedef struct {
    logic signed [31:0] pcount;
    logic signed [31:0] wcount;
    logic [15:0]        dt_us;
    bit                 typed;
    logic signed [31:0] drive;
    logic               bal;
  } sample_row_t;

  typedef struct {
    logic signed [31:0] drive;
    logic               bal;
  } drive_cmd_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  pscb_in_if  in_ch ();
  pscb_out_if out_ch ();

  pendulum_swingup_balance_control DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ctl_regs_t regs;
  longint p_ang, p_rate, w_ang, w_rate;
  longint err_vec [4];
  drive_cmd_t pending_cmds [$];
  int fail_count = 0;
  int sent = 0, got = 0, bal_seen = 0;
  bit stim_done = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fshift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint qmul(longint a, longint b, int s);
    return fshift(a * b, s);
  endfunction

  function automatic longint cosine_q(longint a);
    longint divs [6] = '{132, 90, 56, 30, 12, 2};
    longint x, y2, t;
    bit neg;
    x = a <<< (30 - pscb_pkg::FRAC_BITS);
    neg = 0;
    if (x > pscb_pkg::PI30) x = 2 * pscb_pkg::PI30 - x;
    if (x < 0) x = 0;
    if (x > pscb_pkg::HALF_PI30) begin
      x = pscb_pkg::PI30 - x;
      neg = 1;
    end
    if (x < 0) x = 0;
    y2 = qmul(x, x, 30);
    t = pscb_pkg::ONE30;
    for (int i = 0; i < 6; i++) t = pscb_pkg::ONE30 - qmul(y2, t, 30) / divs[i];
    if (neg) t = -t;
    return fshift(t + pscb_pkg::COS_RND, 30 - pscb_pkg::FRAC_BITS);
  endfunction

  function automatic void reset_controller();
    regs = '{-1190861, -113141, 203, 98, 0, 0, 0, 524288};
    p_ang = 0; p_rate = 0; w_ang = 0; w_rate = 0;
    foreach (err_vec[i]) err_vec[i] = 0;
  endfunction

  function automatic void set_reg(pscb_pkg::reg_idx_t idx, logic [31:0] v);
    case (idx)
      pscb_pkg::REG_GAIN_PA: regs.gpa = longint'(signed'(v));
      pscb_pkg::REG_GAIN_PR: regs.gpr = longint'(signed'(v));
      pscb_pkg::REG_GAIN_WA: regs.gwa = longint'(signed'(v));
      pscb_pkg::REG_GAIN_WR: regs.gwr = longint'(signed'(v));
      pscb_pkg::REG_INERTIA: regs.inertia = longint'(v[30:0]);
      pscb_pkg::REG_MGL:     regs.mgl = longint'(v[30:0]);
      pscb_pkg::REG_EREF:    regs.eref = longint'(signed'(v));
      pscb_pkg::REG_SWING:   regs.swing = longint'(signed'(v));
      default: ;
    endcase
  endfunction

  function automatic drive_cmd_t control_step(logic signed [31:0] pc_in,
                                              logic signed [31:0] wc_in, logic [15:0] dt_in);
    drive_cmd_t c;
    longint pc, wc, dt, r, np, nw, diff, r2, kin, pot, en, de, t, s;
    pc = pc_in; wc = wc_in; dt = dt_in;
    if (p_ang > pscb_pkg::BAND_LO && p_ang < pscb_pkg::BAND_HI) begin
      s = qmul(regs.gpa, err_vec[0], pscb_pkg::FRAC_BITS)
        + qmul(regs.gpr, err_vec[1], pscb_pkg::FRAC_BITS)
        + qmul(regs.gwa, err_vec[2], pscb_pkg::FRAC_BITS)
        + qmul(regs.gwr, err_vec[3], pscb_pkg::FRAC_BITS);
      c.drive = 32'(sat(s));
      c.bal = 1'b1;
    end else begin
      r2 = sat(qmul(p_rate, p_rate, pscb_pkg::FRAC_BITS));
      kin = fshift(sat(qmul(regs.inertia, r2, pscb_pkg::FRAC_BITS)), 1);
      pot = sat(qmul(regs.mgl, pscb_pkg::ONE_Q - cosine_q(p_ang), pscb_pkg::FRAC_BITS));
      en = sat(kin + pot);
      de = sat(en - regs.eref);
      t = sat(qmul(regs.swing, de, pscb_pkg::FRAC_BITS));
      c.drive = 32'(sat(qmul(t, p_rate, pscb_pkg::FRAC_BITS)));
      c.bal = 1'b0;
    end
    r = pc % pscb_pkg::PCNT_REV;
    if (r < 0) r += pscb_pkg::PCNT_REV;
    np = fdiv(r * pscb_pkg::TWO_PI_Q + pscb_pkg::PCNT_HALF, pscb_pkg::PCNT_REV);
    if (np >= pscb_pkg::TWO_PI_Q) np -= pscb_pkg::TWO_PI_Q;
    nw = sat(fdiv(wc * pscb_pkg::TWO_PI_Q + pscb_pkg::WCNT_HALF, pscb_pkg::WCNT_REV));
    err_vec[0] = np - pscb_pkg::PI_Q;
    err_vec[1] = p_rate;
    err_vec[2] = nw;
    err_vec[3] = w_rate;
    if (dt == 0) dt = 1;
    diff = np - p_ang;
    if (diff >= pscb_pkg::PI_Q) diff -= pscb_pkg::TWO_PI_Q;
    if (diff < -pscb_pkg::PI_Q) diff += pscb_pkg::TWO_PI_Q;
    p_rate = sat(diff * pscb_pkg::US_PER_S / dt);
    w_rate = sat((nw - w_ang) * pscb_pkg::US_PER_S / dt);
    p_ang = np;
    w_ang = nw;
    return c;
  endfunction

  // setup then access; the caller drops psel after the last write
  task automatic write_reg(pscb_pkg::reg_idx_t idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    set_reg(idx, v);
  endtask

  task automatic send_sample(logic signed [31:0] pc, logic signed [31:0] wc,
                             logic [15:0] dt, bit typed, logic signed [31:0] drv, logic bal);
    drive_cmd_t c;
    int n;
    n = $urandom_range(0, 15);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pendulum_count <= pc;
    in_ch.wheel_count <= wc;
    in_ch.elapsed_us <= dt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    c = control_step(pc, wc, dt);
    if (typed) begin
      if (c.drive !== drv) begin
        $error("table drive: expected %0d predicted %0d", drv, c.drive);
        fail_count++;
      end
      if (c.bal !== bal) begin
        $error("table balancing: expected %0d predicted %0d", bal, c.bal);
        fail_count++;
      end
      c.drive = drv;
      c.bal = bal;
    end
    pending_cmds.push_back(c);
    sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // receiver waits a random number of cycles before taking each command
  initial begin
    drive_cmd_t e;
    int n;
    out_ch.ready = 0;
    forever begin
      n = $urandom_range(0, 15);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got++;
      if (pending_cmds.size() == 0) begin
        $error("drive command with no request outstanding");
        fail_count++;
      end else begin
        e = pending_cmds.pop_front();
        if (out_ch.balancing) bal_seen++;
        if (out_ch.drive !== e.drive) begin
          $error("drive: expected %0d actual %0d", e.drive, out_ch.drive);
          fail_count++;
        end
        if (out_ch.balancing !== e.bal) begin
          $error("balancing: expected %0d actual %0d", e.bal, out_ch.balancing);
          fail_count++;
        end
      end
    end
  end

  sample_row_t directed [16] = '{
    // from reset all state is zero and the inertia terms vanish
    '{32'sd0, 32'sd0, 16'd1000, 1, 32'sd0, 1'b0},
    '{32'sd4100, 32'sd0, 16'd1000, 1, 32'sd0, 1'b0},
    '{32'sd4100, 32'sd0, 16'd1000, 0, 0, 0},
    '{32'sd4099, 32'sd400, 16'd65535, 0, 0, 0},
    '{32'sh7fffffff, 32'sh7fffffff, 16'd0, 0, 0, 0},
    '{-32'sh80000000, -32'sh80000000, 16'd1, 0, 0, 0},
    '{-32'sd1, -32'sd1, 16'hffff, 0, 0, 0},
    '{32'sd8199, 32'sd799, 16'd1, 0, 0, 0},
    '{32'sd1, 32'sd1, 16'd1, 0, 0, 0},
    '{32'sd4072, 32'sd0, 16'd1000, 0, 0, 0},
    '{32'sd4120, 32'sd5, 16'd1000, 0, 0, 0},
    '{32'sd4110, -32'sd5, 16'd1000, 0, 0, 0},
    '{32'sd4105, 32'sd3, 16'h5555, 0, 0, 0},
    '{32'sd4100, 32'sd0, 16'haaaa, 0, 0, 0},
    '{32'sd2050, 32'sd200, 16'd500, 0, 0, 0},
    '{32'sd6150, -32'sd200, 16'd500, 0, 0, 0}
  };

  initial begin
    logic signed [31:0] pc, wc;
    int base, w;
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_ch.valid = 0; in_ch.pendulum_count = 0; in_ch.wheel_count = 0; in_ch.elapsed_us = 1;
    reset_controller();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed[i])
      send_sample(directed[i].pcount, directed[i].wcount, directed[i].dt_us,
                  directed[i].typed, directed[i].drive, directed[i].bal);
    wait_idle();

    // plant constants for swing-up, then extremes, then random settings
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        write_reg(pscb_pkg::REG_INERTIA, 32'd655);
        write_reg(pscb_pkg::REG_MGL, 32'd20000);
        write_reg(pscb_pkg::REG_EREF, 32'd30000);
      end else if (ph == 1) begin
        write_reg(pscb_pkg::REG_GAIN_PA, 32'h7fffffff);
        write_reg(pscb_pkg::REG_GAIN_PR, 32'h80000000);
        write_reg(pscb_pkg::REG_GAIN_WA, 32'h7fffffff);
        write_reg(pscb_pkg::REG_GAIN_WR, 32'h80000000);
        write_reg(pscb_pkg::REG_INERTIA, 32'hffffffff);
        write_reg(pscb_pkg::REG_MGL, 32'h7fffffff);
        write_reg(pscb_pkg::REG_EREF, 32'h80000000);
        write_reg(pscb_pkg::REG_SWING, 32'h7fffffff);
      end else if (ph == 2) begin
        write_reg(pscb_pkg::REG_GAIN_PA, 32'h80000000);
        write_reg(pscb_pkg::REG_GAIN_PR, 32'h7fffffff);
        write_reg(pscb_pkg::REG_GAIN_WA, 32'h80000000);
        write_reg(pscb_pkg::REG_GAIN_WR, 32'h7fffffff);
        write_reg(pscb_pkg::REG_INERTIA, 32'h0);
        write_reg(pscb_pkg::REG_MGL, 32'h0);
        write_reg(pscb_pkg::REG_EREF, 32'h7fffffff);
        write_reg(pscb_pkg::REG_SWING, 32'h80000000);
      end else begin
        for (int r = 0; r < 8; r++)
          write_reg(pscb_pkg::reg_idx_t'(3'(r)),
                    (ph == 3) ? $urandom() : $urandom_range(0, 200000));
      end
      psel <= 0; penable <= 0; pwrite <= 0;
      // counts mostly near a base angle that is upright half the time, so the balance law is reached
      for (int k = 0; k < 100; k++) begin
        w = $urandom_range(0, 9);
        base = $urandom_range(0, 1) ? 4100 : $urandom_range(0, 8199);
        if (w < 6)
          pc = base + $signed($urandom_range(0, 60)) - 30
               + 8200 * $signed($urandom_range(0, 4) - 2);
        else pc = $urandom();
        wc = (w < 7) ? $signed($urandom_range(0, 4000)) - 2000 : $urandom();
        send_sample(pc, wc, (w == 9) ? 16'($urandom()) : 16'($urandom_range(500, 2000)),
                    0, 0, 0);
      end
      wait_idle();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    $display("covered %0d samples, %0d drive commands, %0d from the balance law",
             sent, got, bal_seen);
    if (fail_count == 0 && pending_cmds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
